// ===== src/tfdi_pkg.sv =====
// Shared widths, types and helpers of the tetrahedron face dedup indexer.
package tfdi_pkg;

    localparam int VID_W     = 12;
    localparam int FID_W     = 15;
    localparam int NFID_W    = 16;
    localparam int CELL_W    = 20;
    localparam int SLOT_W    = 2;
    localparam int NUM_VERT  = 4096;
    localparam int BKT_DEPTH = 32;
    localparam int LANE_W    = $clog2(BKT_DEPTH);
    localparam int FILL_W    = LANE_W + 1;
    localparam int MAX_FACES = 32768;
    localparam logic [SLOT_W-1:0] LAST_SLOT = 2'd3;

    typedef logic [VID_W-1:0] t_vid;

    typedef struct packed {
        t_vid             mid;
        t_vid             high;
        logic [FID_W-1:0] id;
    } t_entry;

    typedef struct packed {
        logic [FID_W-1:0]  face_id;
        logic              is_new;
        t_vid              vert_low;
        t_vid              vert_mid;
        t_vid              vert_high;
        logic [CELL_W-1:0] cell_index;
        logic [SLOT_W-1:0] face_slot;
        logic              overflow;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              load;
        logic              sort;
        logic              read;
        logic              decide;
        logic              clr;
        t_vid              clr_addr;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    typedef struct packed {
        t_vid lo;
        t_vid md;
        t_vid hi;
    } t_tri;

    function automatic t_tri sort3(t_vid a, t_vid b, t_vid c);
        t_vid x;
        t_vid y;
        t_vid z;
        t_vid t;
        t_tri r;
        x = a;
        y = b;
        z = c;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        r.lo = x;
        r.md = y;
        r.hi = z;
        return r;
    endfunction

endpackage

// ===== src/tfdi_if.sv =====
// Handshake interfaces for tetrahedron items and face result items.
interface tfdi_tet_if;
    logic                valid;
    logic                ready;
    logic [tfdi_pkg::VID_W-1:0] corner_a;
    logic [tfdi_pkg::VID_W-1:0] corner_b;
    logic [tfdi_pkg::VID_W-1:0] corner_c;
    logic [tfdi_pkg::VID_W-1:0] corner_d;
    modport source(output valid, corner_a, corner_b, corner_c, corner_d, input ready);
    modport sink(input valid, corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface tfdi_face_if;
    logic                        valid;
    logic                        ready;
    logic [tfdi_pkg::FID_W-1:0]  face_id;
    logic                        is_new;
    logic [tfdi_pkg::VID_W-1:0]  vert_low;
    logic [tfdi_pkg::VID_W-1:0]  vert_mid;
    logic [tfdi_pkg::VID_W-1:0]  vert_high;
    logic [tfdi_pkg::CELL_W-1:0] cell_index;
    logic [tfdi_pkg::SLOT_W-1:0] face_slot;
    logic                        overflow;
    logic                        last;
    modport source(output valid, face_id, is_new, vert_low, vert_mid, vert_high,
                   cell_index, face_slot, overflow, last, input ready);
    modport sink(input valid, face_id, is_new, vert_low, vert_mid, vert_high,
                 cell_index, face_slot, overflow, last, output ready);
endinterface

// ===== src/tfdi_datapath.sv =====
// Datapath: corner registers, face sort, bucket store, match and result register.
module tfdi_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tfdi_pkg::t_cmd                i_cmd,
    output tfdi_pkg::t_stat               o_stat,
    input  logic [tfdi_pkg::VID_W-1:0]    i_corner_a,
    input  logic [tfdi_pkg::VID_W-1:0]    i_corner_b,
    input  logic [tfdi_pkg::VID_W-1:0]    i_corner_c,
    input  logic [tfdi_pkg::VID_W-1:0]    i_corner_d,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tfdi_pkg::t_result             o_result
);
    import tfdi_pkg::*;

    t_vid              r_v [4];
    logic [CELL_W-1:0] r_cell_ctr;
    logic [CELL_W-1:0] r_cell;
    t_tri              r_f;
    logic [SLOT_W-1:0] r_slot;
    logic [NFID_W-1:0] r_next;
    logic [FILL_W-1:0] r_fill;
    t_entry            r_row [BKT_DEPTH];
    logic              r_out_valid;
    t_result           r_out;

    // Bucket store, one row per smallest vertex id, one lane per entry.
    t_entry            mem_ent [NUM_VERT][BKT_DEPTH];
    logic [FILL_W-1:0] mem_fill [NUM_VERT];

    t_tri              w_sorted;
    logic              w_hit;
    logic [FID_W-1:0]  w_hit_id;
    logic              w_full;
    logic              w_exh;
    logic              w_ins;
    t_entry            w_new;

    always_comb begin
        w_sorted = sort3(r_v[i_cmd.slot], r_v[i_cmd.slot + 2'd1], r_v[i_cmd.slot + 2'd2]);
    end

    // First live entry with matching middle and largest ids.
    always_comb begin
        w_hit    = 1'b0;
        w_hit_id = '0;
        for (int e = 0; e < BKT_DEPTH; e++) begin
            if (!w_hit && (FILL_W'(e) < r_fill) &&
                r_row[e].mid == r_f.md && r_row[e].high == r_f.hi) begin
                w_hit    = 1'b1;
                w_hit_id = r_row[e].id;
            end
        end
    end

    assign w_full   = (r_fill == FILL_W'(BKT_DEPTH));
    assign w_exh    = (r_next >= NFID_W'(MAX_FACES));
    assign w_ins    = !w_hit && !w_full && !w_exh;
    assign w_new.mid  = r_f.md;
    assign w_new.high = r_f.hi;
    assign w_new.id   = r_next[FID_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v[0] <= i_corner_a;
            r_v[1] <= i_corner_b;
            r_v[2] <= i_corner_c;
            r_v[3] <= i_corner_d;
            r_cell <= r_cell_ctr;
        end
        if (i_cmd.sort) begin
            r_f    <= w_sorted;
            r_slot <= i_cmd.slot;
        end
        if (i_cmd.read) begin
            r_fill <= mem_fill[r_f.lo];
            r_row  <= mem_ent[r_f.lo];
        end
        if (i_cmd.clr) begin
            mem_fill[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.decide && w_ins) begin
            mem_fill[r_f.lo] <= r_fill + FILL_W'(1);
        end
        if (i_cmd.decide && w_ins) begin
            mem_ent[r_f.lo][r_fill[LANE_W-1:0]] <= w_new;
        end
        if (i_cmd.decide) begin
            r_out.face_id    <= w_hit ? w_hit_id : (w_ins ? r_next[FID_W-1:0] : '0);
            r_out.is_new     <= w_ins;
            r_out.vert_low   <= r_f.lo;
            r_out.vert_mid   <= r_f.md;
            r_out.vert_high  <= r_f.hi;
            r_out.cell_index <= r_cell;
            r_out.face_slot  <= r_slot;
            r_out.overflow   <= !w_hit && !w_ins;
            r_out.last       <= (r_slot == LAST_SLOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_ctr  <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cell_ctr <= r_cell_ctr + CELL_W'(1);
            end
            if (i_cmd.decide && w_ins) begin
                r_next <= r_next + NFID_W'(1);
            end
            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result        = r_out;

endmodule

// ===== src/tfdi_ctrl.sv =====
// Controller: clearing pass, then sort, read and decide for each of four faces.
module tfdi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tfdi_pkg::t_stat i_stat,
    output tfdi_pkg::t_cmd  o_cmd
);
    import tfdi_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SORT,
        S_READ,
        S_DECIDE
    } t_state;

    t_state            r_state;
    t_vid              r_clr;
    logic [SLOT_W-1:0] r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_slot  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + VID_W'(1);
                    if (r_clr == VID_W'(NUM_VERT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_slot <= '0;
                    if (i_in_valid) begin
                        r_state <= S_SORT;
                    end
                end
                S_SORT: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!i_stat.out_busy) begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= (r_slot == LAST_SLOT) ? S_IDLE : S_SORT;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.sort      = (r_state == S_SORT);
    assign o_cmd.read      = (r_state == S_READ);
    assign o_cmd.decide    = (r_state == S_DECIDE) && !i_stat.out_busy;
    assign o_cmd.clr       = (r_state == S_CLEAR);
    assign o_cmd.clr_addr  = r_clr;
    assign o_cmd.slot      = r_slot;

endmodule

// ===== src/tet_face_dedup_indexer.sv =====
// Top level of the tetrahedron face dedup indexer.
//
//   port    dir  item                                   handshake
//   i_tet   in   four corner vertex ids                 valid/ready
//   o_face  out  face id, flags, sorted ids, cell, slot valid/ready
//
// Each tetrahedron item yields four face items. Each face passes three steps
// (sort, bucket row read, match and write-back); the match step waits while
// the output side stalls and compares all 32 entries of a bucket at once.
// After reset a clearing pass zeroes the 4096 bucket fill counts, one a cycle;
// no item is taken during it. A stalled output holds the pending face; the
// next tetrahedron is taken while the last face of the previous one still waits.
module tet_face_dedup_indexer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfdi_tet_if.sink     i_tet,
    tfdi_face_if.source  o_face
);
    import tfdi_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_res;
    logic    w_ready;
    logic    w_valid;

    // Sequence the faces.
    tfdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tet.valid),
        .o_in_ready (w_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Hold corners, search and update the buckets, register each result.
    tfdi_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_corner_a  (i_tet.corner_a),
        .i_corner_b  (i_tet.corner_b),
        .i_corner_c  (i_tet.corner_c),
        .i_corner_d  (i_tet.corner_d),
        .o_out_valid (w_valid),
        .i_out_ready (o_face.ready),
        .o_result    (w_res)
    );

    assign i_tet.ready       = w_ready;
    assign o_face.valid      = w_valid;
    assign o_face.face_id    = w_res.face_id;
    assign o_face.is_new     = w_res.is_new;
    assign o_face.vert_low   = w_res.vert_low;
    assign o_face.vert_mid   = w_res.vert_mid;
    assign o_face.vert_high  = w_res.vert_high;
    assign o_face.cell_index = w_res.cell_index;
    assign o_face.face_slot  = w_res.face_slot;
    assign o_face.overflow   = w_res.overflow;
    assign o_face.last       = w_res.last;

endmodule

// ===== tb/tfdi_tb_if.sv =====
// Testbench constants used by the driving task and the receiver.
`timescale 1ns / 1ps
package tfdi_tb_pkg;
    localparam int IDLE_MAX = 8;
endpackage

// ===== tb/tb_tet_face_dedup_indexer.sv =====
// Testbench for the tetrahedron face dedup indexer: random and directed tetrahedra, scoreboard check.
`timescale 1ns / 1ps

class face_scoreboard;
    tfdi_pkg::t_result   pending_faces[$];
    tfdi_pkg::t_entry    bucket_rows[tfdi_pkg::NUM_VERT][tfdi_pkg::BKT_DEPTH];
    int                  bucket_fill[tfdi_pkg::NUM_VERT];
    int unsigned         next_id;
    logic [tfdi_pkg::CELL_W-1:0] cell_cnt;
    int                  errors;

    function new();
        next_id  = 0;
        cell_cnt = '0;
        errors   = 0;
        foreach (bucket_fill[i]) bucket_fill[i] = 0;
    endfunction

    // Work out the four faces of an accepted tetrahedron.
    function void note_tet(tfdi_pkg::t_vid a, tfdi_pkg::t_vid b, tfdi_pkg::t_vid c,
                           tfdi_pkg::t_vid d);
        tfdi_pkg::t_vid    v[4];
        tfdi_pkg::t_vid    f[3];
        tfdi_pkg::t_vid    t;
        tfdi_pkg::t_result r;
        tfdi_pkg::t_entry  e;
        bit                hit;
        int                n;
        v[0] = a; v[1] = b; v[2] = c; v[3] = d;
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) f[k] = v[(j + k) % 4];
            if (f[0] > f[1]) begin t = f[0]; f[0] = f[1]; f[1] = t; end
            if (f[1] > f[2]) begin t = f[1]; f[1] = f[2]; f[2] = t; end
            if (f[0] > f[1]) begin t = f[0]; f[0] = f[1]; f[1] = t; end
            r = '0;
            hit = 0;
            n = bucket_fill[f[0]];
            for (int i = 0; i < n; i++) begin
                if (!hit && bucket_rows[f[0]][i].mid == f[1]
                    && bucket_rows[f[0]][i].high == f[2]) begin
                    hit = 1;
                    r.face_id = bucket_rows[f[0]][i].id;
                end
            end
            if (!hit) begin
                if (n >= tfdi_pkg::BKT_DEPTH || next_id >= tfdi_pkg::MAX_FACES) begin
                    r.overflow = 1'b1;
                end else begin
                    e.mid = f[1]; e.high = f[2]; e.id = next_id[tfdi_pkg::FID_W-1:0];
                    bucket_rows[f[0]][n] = e;
                    bucket_fill[f[0]] = n + 1;
                    r.face_id = e.id;
                    r.is_new  = 1'b1;
                    next_id++;
                end
            end
            r.vert_low = f[0]; r.vert_mid = f[1]; r.vert_high = f[2];
            r.cell_index = cell_cnt;
            r.face_slot  = j[tfdi_pkg::SLOT_W-1:0];
            r.last       = (j == 3);
            pending_faces = {pending_faces, r};
        end
        cell_cnt++;
    endfunction

    // Compare one face item against the oldest expectation.
    function void check_face(tfdi_pkg::t_result got);
        tfdi_pkg::t_result x;
        if (pending_faces.size() == 0) begin
            $error("unexpected face item %p", got);
            errors++;
            return;
        end
        x = pending_faces.pop_front();
        if (got.face_id !== x.face_id) begin
            $error("face_id exp %0d got %0d", x.face_id, got.face_id); errors++; end
        if (got.is_new !== x.is_new) begin
            $error("is_new exp %0d got %0d", x.is_new, got.is_new); errors++; end
        if (got.vert_low !== x.vert_low) begin
            $error("vert_low exp %0d got %0d", x.vert_low, got.vert_low); errors++; end
        if (got.vert_mid !== x.vert_mid) begin
            $error("vert_mid exp %0d got %0d", x.vert_mid, got.vert_mid); errors++; end
        if (got.vert_high !== x.vert_high) begin
            $error("vert_high exp %0d got %0d", x.vert_high, got.vert_high); errors++; end
        if (got.cell_index !== x.cell_index) begin
            $error("cell_index exp %0d got %0d", x.cell_index, got.cell_index); errors++; end
        if (got.face_slot !== x.face_slot) begin
            $error("face_slot exp %0d got %0d", x.face_slot, got.face_slot); errors++; end
        if (got.overflow !== x.overflow) begin
            $error("overflow exp %0d got %0d", x.overflow, got.overflow); errors++; end
        if (got.last !== x.last) begin
            $error("last exp %0d got %0d", x.last, got.last); errors++; end
    endfunction
endclass

module tb_tet_face_dedup_indexer;
    import tfdi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    tfdi_tet_if  tet_bus();
    tfdi_face_if face_bus();

    face_scoreboard sb = new();
    int unsigned    cycle_cnt = 0;
    // Vertex pool: mostly small ids so faces get shared, plus ids 0 and NUM_VERT - 1.
    t_vid           pool[16];

    tet_face_dedup_indexer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tet   (tet_bus),
        .o_face  (face_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        tet_bus.valid = 1'b0;
        tet_bus.corner_a = '0; tet_bus.corner_b = '0;
        tet_bus.corner_c = '0; tet_bus.corner_d = '0;
        face_bus.ready = 1'b0;
    end

    // Bound the run; covers the clearing pass after reset too.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Pick a vertex id, mostly from the shared pool.
    function automatic t_vid rv();
        if ($urandom_range(0, 3) == 0) begin
            return t_vid'($urandom_range(0, NUM_VERT - 1));
        end
        return pool[4'($urandom_range(0, 15))];
    endfunction

    // Offer one tetrahedron and hold it until accepted.
    task automatic send_tet(t_vid a, t_vid b, t_vid c, t_vid d, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, tfdi_tb_pkg::IDLE_MAX);
        if (gap > 0) begin
            tet_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tet_bus.valid    <= 1'b1;
        tet_bus.corner_a <= a; tet_bus.corner_b <= b;
        tet_bus.corner_c <= c; tet_bus.corner_d <= d;
        do @(posedge i_clk); while (!tet_bus.ready);
        sb.note_tet(a, b, c, d);
    endtask

    // Drop valid and hold until every expected face item has come back.
    task automatic drain();
        tet_bus.valid <= 1'b0;
        while (sb.pending_faces.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        foreach (pool[i]) pool[i] = t_vid'($urandom_range(0, 24));
        pool[0] = '0;
        pool[1] = t_vid'(NUM_VERT - 1);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Push the bucket of vertex 0 past its depth.
        for (int k = 0; k < 12; k++) begin
            send_tet('0, t_vid'(100 + 3 * k), t_vid'(101 + 3 * k), t_vid'(102 + 3 * k));
        end
        // Repeated ids, and one tetrahedron sent twice back to back.
        send_tet(t_vid'(5), t_vid'(5), t_vid'(5), t_vid'(5));
        send_tet(t_vid'(NUM_VERT - 1), t_vid'(NUM_VERT - 1), '0, t_vid'(1));
        send_tet(t_vid'(7), t_vid'(8), t_vid'(9), t_vid'(10), 1'b1);
        send_tet(t_vid'(7), t_vid'(8), t_vid'(9), t_vid'(10), 1'b1);
        drain();
        for (int n = 0; n < 104; n++) begin
            send_tet(rv(), rv(), rv(), rv(), ($urandom_range(0, 3) == 0));
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: stall a random number of cycles per item, with calm stretches.
    initial begin
        int stall;
        tfdi_pkg::t_result got;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, tfdi_tb_pkg::IDLE_MAX);
            if (cycle_cnt % 3000 < 600) stall = 0;
            if (stall > 0) begin
                face_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            face_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!face_bus.valid);
            got.face_id = face_bus.face_id;   got.is_new = face_bus.is_new;
            got.vert_low = face_bus.vert_low; got.vert_mid = face_bus.vert_mid;
            got.vert_high = face_bus.vert_high; got.cell_index = face_bus.cell_index;
            got.face_slot = face_bus.face_slot; got.overflow = face_bus.overflow;
            got.last = face_bus.last;
            sb.check_face(got);
        end
    end

endmodule
